/* design/md4_pkg.sv */
package md4_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md4_abcd_t;

    localparam logic [31:0] MD4_K2 = 32'h5a827999;
    localparam logic [31:0] MD4_K3 = 32'h6ed9eba1;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int ROUND_W  = 6;
    localparam int FILL_W   = 6;
    localparam int WADDR_W  = 4;
    localparam int LAST_RND = 47;

    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;

    // Message word used by a round: identity, column order or bit-reversed order.
    function automatic logic [WADDR_W-1:0] msg_index(input logic [ROUND_W-1:0] rnd);
        logic [3:0] j;
        logic [3:0] idx;
        j = rnd[3:0];
        case (rnd[5:4])
            GRP_F:   idx = j;
            GRP_G:   idx = {j[1:0], j[3:2]};
            default: idx = {j[0], j[1], j[2], j[3]};
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] shift_amt(input logic [ROUND_W-1:0] rnd);
        logic [4:0] s;
        case (rnd[5:4])
            GRP_F: begin
                case (rnd[1:0])
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd7;
                    2'd2:    s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            GRP_G: begin
                case (rnd[1:0])
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd5;
                    2'd2:    s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default: begin
                case (rnd[1:0])
                    2'd0:    s = 5'd3;
                    2'd1:    s = 5'd9;
                    2'd2:    s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

/* design/md4_buf.sv */
module md4_buf (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [md4_pkg::WADDR_W-1:0] wr_addr,
    input  logic [31:0]                 wr_data,
    input  logic                        rd_en,
    input  logic [md4_pkg::WADDR_W-1:0] rd_addr,
    output logic [31:0]                 rd_data
);
    import md4_pkg::*;

    logic [31:0] mem [2**WADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/md4_round.sv */
module md4_round (
    input  md4_pkg::md4_abcd_t          st_i,
    input  logic [31:0]                 x_i,
    input  logic [md4_pkg::ROUND_W-1:0] rnd_i,
    output md4_pkg::md4_abcd_t          st_o
);
    import md4_pkg::*;

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] sum;
    logic [63:0] rot;
    logic [4:0]  s;

    always_comb begin
        case (rnd_i[5:4])
            GRP_F: begin
                f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
                k = '0;
            end
            GRP_G: begin
                f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
                k = MD4_K2;
            end
            default: begin
                f = st_i.b ^ st_i.c ^ st_i.d;
                k = MD4_K3;
            end
        endcase
        s   = shift_amt(rnd_i);
        sum = st_i.a + f + x_i + k;
        // Rotate left by shifting a doubled copy and keeping the upper half.
        rot = {sum, sum} << s;
        st_o.a = st_i.d;
        st_o.b = rot[63:32];
        st_o.c = st_i.b;
        st_o.d = st_i.c;
    end

endmodule

/* design/md4_hash_engine_top.sv */
// MD4 digest engine fed one message byte per request. Append requests are taken back to
// back, except that the one that fills a 64-byte block leaves the engine not ready
// while the single shared round unit runs: it fetches the first message word from the
// 16-word block buffer (ST_LOAD), runs 48 rounds at one per cycle (ST_COMP), then folds
// the result into the chaining words (ST_ADD). A finish request generates the padding and
// the little-endian bit length internally at one byte per cycle between compressions,
// compressing once or twice along the way, then presents the four digest words A to D
// on the result channel; after the last word is taken the engine is back at its
// initial values and ready for a new message, including an empty one.
module md4_hash_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word
);
    import md4_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam logic ACT_APPEND = 1'b0;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [60:0]        byte_cnt_reg, byte_cnt_next;
    logic [23:0]        pack_reg, pack_next;
    md4_abcd_t          chain_reg, chain_next;
    md4_abcd_t          work_reg, work_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic               pad_first_reg, pad_first_next;
    logic               len_phase_reg, len_phase_next;
    logic               fin_reg, fin_next;
    logic [1:0]         out_idx_reg, out_idx_next;

    logic               put_en;
    logic [7:0]         put_byte;
    logic               is_len;
    logic [63:0]        len_bits;
    logic               buf_wr_en;
    logic               buf_rd_en;
    logic [WADDR_W-1:0] buf_rd_addr;
    logic [31:0]        buf_rd_data;
    md4_abcd_t          round_out;

    assign len_bits = {byte_cnt_reg, 3'b000};
    assign is_len   = !pad_first_reg && (len_phase_reg || (fill_reg == FILL_W'(56)));

    assign buf_wr_en   = put_en && (fill_reg[1:0] == 2'd3);
    assign buf_rd_en   = (state_reg == ST_LOAD) || (state_reg == ST_COMP);
    assign buf_rd_addr = msg_index((state_reg == ST_LOAD) ? rnd_reg
                                                          : ROUND_W'(rnd_reg + 1'b1));

    md4_buf u_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (fill_reg[FILL_W-1:2]),
        .wr_data ({put_byte, pack_reg}),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    md4_round u_round (
        .st_i  (work_reg),
        .x_i   (buf_rd_data),
        .rnd_i (rnd_reg),
        .st_o  (round_out)
    );

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        byte_cnt_next  = byte_cnt_reg;
        pack_next      = pack_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        rnd_next       = rnd_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        fin_next       = fin_reg;
        out_idx_next   = out_idx_reg;
        put_en         = 1'b0;
        put_byte       = s_data_byte;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_APPEND) begin
                        put_en        = 1'b1;
                        byte_cnt_next = byte_cnt_reg + 61'd1;
                    end else begin
                        fin_next       = 1'b1;
                        pad_first_next = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                put_en         = 1'b1;
                pad_first_next = 1'b0;
                len_phase_next = len_phase_reg | is_len;
                if (pad_first_reg) begin
                    put_byte = PAD_BYTE;
                end else if (is_len) begin
                    put_byte = len_bits[{fill_reg[2:0], 3'b000} +: 8];
                end else begin
                    put_byte = '0;
                end
            end
            ST_LOAD: begin
                work_next  = chain_reg;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                work_next = round_out;
                if (rnd_reg == ROUND_W'(LAST_RND)) begin
                    rnd_next   = '0;
                    state_next = ST_ADD;
                end else begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            ST_ADD: begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (len_phase_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == 2'd3) begin
                        chain_next     = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
                        byte_cnt_next  = '0;
                        fin_next       = 1'b0;
                        len_phase_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Shared byte path: bytes gather little-endian, a word is written on its fourth byte.
        if (put_en) begin
            pack_next = {put_byte, pack_reg[23:8]};
            fill_next = fill_reg + 1'b1;
            if (fill_reg == FILL_W'(63)) begin
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            byte_cnt_reg  <= '0;
            chain_reg     <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            rnd_reg       <= '0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            fin_reg       <= 1'b0;
            out_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            byte_cnt_reg  <= byte_cnt_next;
            chain_reg     <= chain_next;
            rnd_reg       <= rnd_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            fin_reg       <= fin_next;
            out_idx_reg   <= out_idx_next;
        end
        pack_reg <= pack_next;
        work_reg <= work_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        case (out_idx_reg)
            2'd0:    m_digest_word = chain_reg.a;
            2'd1:    m_digest_word = chain_reg.b;
            2'd2:    m_digest_word = chain_reg.c;
            default: m_digest_word = chain_reg.d;
        endcase
    end

    assign m_word_index = out_idx_reg;
    assign m_last_word  = (out_idx_reg == 2'd3);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest is being presented");

    a_fill_starts_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_APPEND) && (fill_reg == FILL_W'(63)))
        |=> (state_reg == ST_LOAD))
        else $error("full block did not start compression");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP) |-> (rnd_reg <= ROUND_W'(LAST_RND)))
        else $error("round counter out of range");

    a_digest_at_block_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (fill_reg == '0))
        else $error("digest presented with a partly filled block");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && (byte_cnt_reg == '0)))
        else $error("engine did not return to its initial state after the digest");

endmodule

/* test/md4_test_pkg.sv */
package md4_test_pkg;

    typedef enum logic {
        MSG_APPEND = 1'b0,
        MSG_FINISH = 1'b1
    } msg_action_e;

    localparam logic [1:0] FINAL_WORD_IDX = 2'd3;

endpackage

/* test/md4_digest_checker.sv */
module md4_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_digest_word,
    input  logic [1:0]  m_word_index,
    input  logic        m_last_word,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import md4_pkg::*;
    import md4_test_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_rec_t;

    // Per-round rotate amounts, four to a group, lowest entry first.
    localparam logic [19:0] F_ROTS = {5'd19, 5'd11, 5'd7, 5'd3};
    localparam logic [19:0] G_ROTS = {5'd13, 5'd9, 5'd5, 5'd3};
    localparam logic [19:0] H_ROTS = {5'd15, 5'd11, 5'd9, 5'd3};

    md4_abcd_t   chain_state;
    logic [63:0] bit_total;
    logic [7:0]  block_buf [64];
    logic [5:0]  fill_pos;
    digest_rec_t digest_fifo [$];

    task automatic report_error(input string msg);
        $display("digest check: %s", msg);
        fail_count++;
    endtask

    function automatic int round_word(input int r);
        int j;
        j = r % 16;
        if (r < 16) begin
            return j;
        end else if (r < 32) begin
            return (j % 4) * 4 + j / 4;
        end
        // Third group walks the words in bit-reversed order.
        return ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
    endfunction

    function automatic int round_rot(input int r);
        int col;
        col = r % 4;
        if (r < 16) begin
            return F_ROTS[5*col +: 5];
        end else if (r < 32) begin
            return G_ROTS[5*col +: 5];
        end
        return H_ROTS[5*col +: 5];
    endfunction

    function automatic void md4_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, x, sum, t;
        int          s;
        for (int k = 0; k < 16; k++) begin
            w[k] = {block_buf[4*k+3], block_buf[4*k+2], block_buf[4*k+1], block_buf[4*k]};
        end
        a = chain_state.a;
        b = chain_state.b;
        c = chain_state.c;
        d = chain_state.d;
        for (int r = 0; r < 48; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d);
                x = w[round_word(r)];
            end else if (r < 32) begin
                f = (b & c) | (b & d) | (c & d);
                x = w[round_word(r)] + MD4_K2;
            end else begin
                f = b ^ c ^ d;
                x = w[round_word(r)] + MD4_K3;
            end
            s   = round_rot(r);
            sum = a + f + x;
            t   = (sum << s) | (sum >> (32 - s));
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_state.a = chain_state.a + a;
        chain_state.b = chain_state.b + b;
        chain_state.c = chain_state.c + c;
        chain_state.d = chain_state.d + d;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        block_buf[fill_pos] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0) begin
            md4_compress();
        end
    endfunction

    function automatic void restart_message();
        chain_state = {IV_A, IV_B, IV_C, IV_D};
        bit_total   = 64'd0;
        fill_pos    = 6'd0;
    endfunction

    function automatic void close_message();
        logic [63:0] msg_bits;
        digest_rec_t rec;
        msg_bits = bit_total;
        absorb_byte(PAD_BYTE);
        while (fill_pos != 6'd56) begin
            absorb_byte(8'h00);
        end
        for (int k = 0; k < 8; k++) begin
            absorb_byte(msg_bits[8*k +: 8]);
        end
        for (int k = 0; k < 4; k++) begin
            rec.word  = chain_state[32*(3-k) +: 32];
            rec.index = 2'(k);
            rec.last  = (2'(k) == FINAL_WORD_IDX);
            digest_fifo.push_back(rec);
        end
        restart_message();
    endfunction

    always @(posedge aclk) begin : digest_watch
        digest_rec_t want;
        if (!aresetn) begin
            restart_message();
            digest_fifo.delete();
        end else begin
            // A word leaving this cycle cannot belong to a request taken in this same cycle.
            if (m_valid && m_ready) begin
                if (digest_fifo.size() == 0) begin
                    report_error($sformatf("unexpected word %h index %0d",
                                           m_digest_word, m_word_index));
                end else begin
                    want = digest_fifo.pop_front();
                    if (m_digest_word !== want.word) begin
                        report_error($sformatf("word %0d is %h, want %h",
                                               want.index, m_digest_word, want.word));
                    end
                    if (m_word_index !== want.index) begin
                        report_error($sformatf("index is %0d, want %0d",
                                               m_word_index, want.index));
                    end
                    if (m_last_word !== want.last) begin
                        report_error($sformatf("last flag on word %0d is %b, want %b",
                                               want.index, m_last_word, want.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_action == MSG_FINISH) begin
                    close_message();
                end else begin
                    bit_total = bit_total + 64'd8;
                    absorb_byte(s_data_byte);
                end
            end
        end
        pending_count = digest_fifo.size();
    end

endmodule

/* test/md4_hash_engine_top_test.sv */
module md4_hash_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import md4_test_pkg::*;

    localparam int RANDOM_REQUESTS = 110;
    localparam int HOLD_AFTER_WORDS = 28;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [1:0]  m_word_index;
    logic        m_last_word;

    int fail_cnt;
    int pending_cnt;

    // Handshakes as seen at the last rising edge; the driving processes read these.
    logic req_taken = 1'b0;
    logic word_taken = 1'b0;

    int   requests_sent = 0;
    logic sender_burst = 1'b0;

    always #5 aclk = ~aclk;

    md4_hash_engine_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    md4_digest_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word),
        .fail_count    (fail_cnt),
        .pending_count (pending_cnt)
    );

    always @(posedge aclk) begin
        req_taken  <= s_valid && s_ready;
        word_taken <= m_valid && m_ready;
    end

    task automatic push_request(input msg_action_e act, input logic [7:0] value);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_action    = act;
        s_data_byte = value;
        do @(negedge aclk); while (!req_taken);
        requests_sent++;
    endtask

    task automatic hash_random_message(input int len);
        sender_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            push_request(MSG_APPEND, 8'($urandom_range(0, 255)));
        end
        // The byte on a finish is ignored, but it still gets random content.
        push_request(MSG_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_digests_drained();
        s_valid = 1'b0;
        while (pending_cnt != 0) @(negedge aclk);
    endtask

    function automatic int pick_message_length();
        int r;
        int len;
        int room;
        // Keep the whole run close to the planned number of requests.
        room = RANDOM_REQUESTS - requests_sent - 1;
        if (room < 0) begin
            room = 0;
        end
        r = $urandom_range(0, 9);
        if (r < 6) begin
            len = $urandom_range(0, 12);
        end else if (r < 9) begin
            // Around the point where the length field no longer fits the last block.
            len = $urandom_range(52, 65);
        end else begin
            len = $urandom_range(110, 130);
        end
        return (len > room) ? room : len;
    endfunction

    initial begin : sender
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Empty message, then "abc", then single bytes at both extremes, then a two-byte message.
        push_request(MSG_FINISH, 8'hFF);
        push_request(MSG_APPEND, 8'h61);
        push_request(MSG_APPEND, 8'h62);
        push_request(MSG_APPEND, 8'h63);
        push_request(MSG_FINISH, 8'h00);
        push_request(MSG_APPEND, 8'h00);
        push_request(MSG_FINISH, 8'hA5);
        push_request(MSG_APPEND, 8'hFF);
        push_request(MSG_FINISH, 8'h5A);
        push_request(MSG_APPEND, 8'h55);
        push_request(MSG_APPEND, 8'hAA);
        push_request(MSG_FINISH, 8'h00);
        // A second empty message right after a finish starts from the initial values.
        push_request(MSG_FINISH, 8'h00);

        wait_digests_drained();

        // A 56-byte message needs a second padding block.
        hash_random_message(56);
        while (requests_sent < RANDOM_REQUESTS / 2) begin
            hash_random_message(pick_message_length());
        end
        wait_digests_drained();
        while (requests_sent < RANDOM_REQUESTS) begin
            hash_random_message(pick_message_length());
        end

        wait_digests_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : receiver
        int words_seen;
        int stall;
        int calm;
        words_seen = 0;
        calm = 0;
        forever begin
            if (words_seen == HOLD_AFTER_WORDS) begin
                // Long hold-off so the engine backs up and stops taking requests.
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (calm > 0) begin
                    calm--;
                    stall = 0;
                end else begin
                    if ($urandom_range(0, 5) == 0) begin
                        calm = 8;
                    end
                    stall = $urandom_range(0, 14);
                end
                if (stall > 0) begin
                    m_ready = 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready = 1'b1;
            do @(negedge aclk); while (!word_taken);
            words_seen++;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if (req_taken || word_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
